/* rtl/cmsk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmsk_pkg
// Shared constants and types for the conservative count-min sketch.
// ----------------------------------------------------------------------------
package cmsk_pkg;

  localparam int MAX_ROWS     = 8;
  localparam int MAX_COLUMNS  = 4096;
  localparam int COUNTER_BITS = 32;

  // Fixed field widths
  localparam int HASH_W  = 32;
  localparam int OUT_W   = 32;
  localparam int ROWS_W  = 4;
  localparam int COLS_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int ROWS_RESET = 8;
  localparam int COLS_RESET = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = CFG_IDX_W'(1);

  // Counter table geometry: address is {row, column}
  localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_BITS  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ADDR_BITS = ROW_BITS + COL_BITS;
  localparam int TBL_DEPTH = MAX_ROWS * (1 << COL_BITS);
  localparam int RCNT_W    = $clog2(MAX_ROWS + 1);

  // Remainder unit: bits of dividend consumed per cycle
  localparam int MOD_STEP   = 8;
  localparam int MOD_CYCLES = HASH_W / MOD_STEP;
  localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

  typedef logic [COUNTER_BITS-1:0] ctr_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [COLS_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [COLS_W-1:0] rem;
  } mod_rsp_t;

endpackage

/* rtl/count_min_sketch_conservative_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// count_min_sketch_conservative_top
// Count-min sketch with conservative update over one counter RAM.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start && !busy          in_action, in_hash_low, in_hash_high
//  result    out_valid (one cycle)   out_estimate, out_total_entries,
//                                    out_unique_entries
//  config    cfg_valid && cfg_ready  cfg_index, cfg_data
//
//  Each row waits on the remainder unit before its RAM read, and a store
//  adds one write slot per row on the single write port.
//  After reset the RAM is zeroed one entry a cycle with busy high; config
//  writes are taken throughout. The receiver cannot stall.
// ----------------------------------------------------------------------------
module count_min_sketch_conservative_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_action,
  input  logic [cmsk_pkg::HASH_W-1:0]         in_hash_low,
  input  logic [cmsk_pkg::HASH_W-1:0]         in_hash_high,
  output logic                                out_valid,
  output logic [cmsk_pkg::OUT_W-1:0]          out_estimate,
  output logic [cmsk_pkg::OUT_W-1:0]          out_total_entries,
  output logic [cmsk_pkg::OUT_W-1:0]          out_unique_entries,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cmsk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cmsk_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cmsk_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_BUMP  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  localparam ctr_t CTR_MAX = {COUNTER_BITS{1'b1}};

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_r, clr_nxt;
  logic [ROWS_W-1:0]   rows_cfg_r;
  logic [COLS_W-1:0]   cols_cfg_r;
  logic                action_r, action_nxt;
  logic [HASH_W-1:0]   step_r, step_nxt;
  logic [HASH_W-1:0]   idx_r, idx_nxt;
  logic [RCNT_W-1:0]   rows_r, rows_nxt;
  logic [COLS_W-1:0]   cols_r, cols_nxt;
  logic [RCNT_W-1:0]   row_r, row_nxt;
  logic [ROW_BITS-1:0] rd_row_r, rd_row_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  ctr_t                est_r, est_nxt;
  logic [OUT_W-1:0]    total_r, total_nxt;
  logic [OUT_W-1:0]    unique_r, unique_nxt;
  logic                out_valid_r, out_valid_nxt;

  ctr_t                vals_r [MAX_ROWS];
  logic [COL_BITS-1:0] slot_r [MAX_ROWS];

  logic [RCNT_W-1:0]   rows_eff;
  logic [COLS_W-1:0]   cols_eff;
  ctr_t                est_min;
  logic [ROW_BITS-1:0] row_idx;
  logic                last_read;
  logic                last_write;

  mod_req_t            mreq;
  mod_rsp_t            mrsp;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  ctr_t                 ram_wdata;
  logic [ADDR_BITS-1:0] ram_raddr;
  ctr_t                 ram_rdata;

  // config port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= ROWS_W'(ROWS_RESET);
      cols_cfg_r <= COLS_W'(COLS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS:    rows_cfg_r <= cfg_data[ROWS_W-1:0];
        REG_COLUMNS: cols_cfg_r <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry to the supported range
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (RCNT_W'(rows_cfg_r) > RCNT_W'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_eff = COLS_W'(1);
    end else if (cols_cfg_r > COLS_W'(MAX_COLUMNS)) begin
      cols_eff = COLS_W'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_cfg_r;
    end
  end

  assign row_idx    = row_r[ROW_BITS-1:0];
  assign est_min    = (ram_rdata < est_r) ? ram_rdata : est_r;
  assign last_read  = rd_pend_r && (RCNT_W'(rd_row_r) == rows_r - RCNT_W'(1));
  assign last_write = (row_r == rows_r - RCNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    action_nxt    = action_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    row_nxt       = row_r;
    rd_row_nxt    = rd_row_r;
    rd_pend_nxt   = 1'b0;
    est_nxt       = est_r;
    total_nxt     = total_r;
    unique_nxt    = unique_r;
    out_valid_nxt = 1'b0;

    mreq.start    = 1'b0;
    mreq.dividend = idx_r + step_r;
    mreq.divisor  = cols_r;

    ram_we    = 1'b0;
    ram_waddr = {row_idx, slot_r[row_idx]};
    ram_wdata = est_r;
    ram_raddr = {row_idx, mrsp.rem[COL_BITS-1:0]};

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_BITS'(1);
        if (clr_r == ADDR_BITS'(TBL_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          action_nxt    = in_action;
          step_nxt      = in_hash_high;
          idx_nxt       = in_hash_low;
          rows_nxt      = rows_eff;
          cols_nxt      = cols_eff;
          row_nxt       = '0;
          est_nxt       = CTR_MAX;
          mreq.start    = 1'b1;
          mreq.dividend = in_hash_low;
          mreq.divisor  = cols_eff;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        // column ready: issue the read and start on the next row
        if (mrsp.done) begin
          rd_pend_nxt = 1'b1;
          rd_row_nxt  = row_idx;
          row_nxt     = row_r + RCNT_W'(1);
          idx_nxt     = idx_r + step_r;
          if (row_r + RCNT_W'(1) < rows_r) begin
            mreq.start = 1'b1;
          end
        end
        if (rd_pend_r) begin
          est_nxt = est_min;
          if (last_read) begin
            if (action_r) begin
              state_nxt = S_BUMP;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
        end
      end
      S_BUMP: begin
        if (est_r != CTR_MAX) begin
          est_nxt = est_r + ctr_t'(1);
        end
        if (total_r != {OUT_W{1'b1}}) begin
          total_nxt = total_r + OUT_W'(1);
        end
        // new value is one exactly when the minimum was zero
        if (est_r == '0 && unique_r != {OUT_W{1'b1}}) begin
          unique_nxt = unique_r + OUT_W'(1);
        end
        row_nxt   = '0;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        ram_we  = (vals_r[row_idx] < est_r);
        row_nxt = row_r + RCNT_W'(1);
        if (last_write) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      unique_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      unique_r    <= unique_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    step_r   <= step_nxt;
    idx_r    <= idx_nxt;
    rows_r   <= rows_nxt;
    cols_r   <= cols_nxt;
    row_r    <= row_nxt;
    rd_row_r <= rd_row_nxt;
    est_r    <= est_nxt;
    if (state_r == S_READ && mrsp.done) begin
      slot_r[row_idx] <= mrsp.rem[COL_BITS-1:0];
    end
    if (rd_pend_r) begin
      vals_r[rd_row_r] <= ram_rdata;
    end
  end

  cmsk_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  cmsk_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (TBL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_estimate       = OUT_W'(est_r);
  assign out_total_entries  = total_r;
  assign out_unique_entries = unique_r;

endmodule

/* rtl/cmsk_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmsk_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cmsk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/cmsk_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmsk_mod
// Iterative remainder unit: 32-bit dividend mod 13-bit divisor,
// restoring steps, MOD_STEP bits per cycle.
// ----------------------------------------------------------------------------
module cmsk_mod (
  input  logic               clk,
  input  logic               rst_n,
  input  cmsk_pkg::mod_req_t req,
  output cmsk_pkg::mod_rsp_t rsp
);
  import cmsk_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic [HASH_W-1:0]    dvd_r;
  logic [COLS_W-1:0]    dsr_r;
  logic [COLS_W-1:0]    rem_r;
  logic [COLS_W-1:0]    rem_nxt;

  always_comb begin
    logic [COLS_W:0] t;
    rem_nxt = rem_r;
    for (int i = 0; i < MOD_STEP; i++) begin
      t = {rem_nxt, dvd_r[HASH_W-1-i]};
      if (t >= {1'b0, dsr_r}) begin
        t = t - {1'b0, dsr_r};
      end
      // remainder stays below the divisor, so the top bit is clear
      rem_nxt = t[COLS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + MOD_CNT_W'(1);
        if (cnt_r == MOD_CNT_W'(MOD_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << MOD_STEP;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
